// File: hw/rtl/lmsc_pkg.sv
// Shared widths, codes and transaction types of the light-mark seek controller.
`timescale 1ns / 1ps
`default_nettype none

package lmsc_pkg;

  // Sample width and the derived widths of levels and threshold arithmetic.
  localparam int SAMPLE_BITS = 10;
  localparam int LVL_W       = SAMPLE_BITS + 1;
  localparam int SCALED_W    = LVL_W + 3;          // holds 7 * delta
  localparam int QUART_W     = SCALED_W - 2;       // 7 * delta / 4
  localparam int CMD_W       = 3;
  localparam int SPEED_W     = 8;
  localparam int ACT_W       = 2;
  localparam int MODE_W      = 2;
  localparam int PHASE_W     = 2;

  // Division by five as a multiply by 52429 / 2^18; exact for dividends below 262000.
  localparam int DIV5_MUL_W  = 16;
  localparam int DIV5_SHIFT  = 18;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;
  localparam int PROD_W      = QUART_W + DIV5_MUL_W;

  // Reset values of the calibration state.
  localparam logic [LVL_W-1:0]   MIN_RST   = LVL_W'(250);
  localparam logic [LVL_W-1:0]   MAX_RST   = LVL_W'(500);
  localparam logic [LVL_W-1:0]   LIGHT_RST = LVL_W'(412);
  localparam logic [LVL_W-1:0]   DARK_RST  = LVL_W'(337);
  localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(5);
  localparam logic [LVL_W-1:0]   MIN_INIT  = LVL_W'(1) << SAMPLE_BITS;

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_SEEK   = 3'd2,
    CMD_INIT   = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  // Motor action codes of a result transaction.
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_BRAKE = 2'd1,
    ACT_FWD   = 2'd2
  } act_t;

  // Input transaction as held in the input register.
  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [SAMPLE_BITS-1:0] light_sample;
    logic [SPEED_W-1:0]     seek_speed;
  } item_t;

  // Result transaction as held in the result register.
  typedef struct packed {
    logic [ACT_W-1:0]       motor_action;
    logic [SPEED_W-1:0]     motor_speed;
    logic [MODE_W-1:0]      mode_now;
    logic [PHASE_W-1:0]     phase_now;
    logic [LVL_W-1:0]       light_level;
    logic [LVL_W-1:0]       dark_level;
    logic                   status_valid;
    logic [SAMPLE_BITS-1:0] sample_echo;
  } res_t;

  // Handshake between the input register and the core.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

`default_nettype wire

// File: hw/rtl/lmsc_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface lmsc_cmd_if;
  import lmsc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [SAMPLE_BITS-1:0] light_sample;
  logic [SPEED_W-1:0]     seek_speed;

  modport source (output valid, command, light_sample, seek_speed, input ready);
  modport sink   (input valid, command, light_sample, seek_speed, output ready);
endinterface

interface lmsc_res_if;
  import lmsc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       motor_action;
  logic [SPEED_W-1:0]     motor_speed;
  logic [MODE_W-1:0]      mode_now;
  logic [PHASE_W-1:0]     phase_now;
  logic [LVL_W-1:0]       light_level;
  logic [LVL_W-1:0]       dark_level;
  logic                   status_valid;
  logic [SAMPLE_BITS-1:0] sample_echo;

  modport source (output valid, motor_action, motor_speed, mode_now, phase_now,
                  light_level, dark_level, status_valid, sample_echo,
                  input ready);
  modport sink   (input valid, motor_action, motor_speed, mode_now, phase_now,
                  light_level, dark_level, status_valid, sample_echo,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lmsc_thresh.sv
// Threshold arithmetic: dark = lo + 7*delta/20, light = (20*hi - 7*delta)/20.
`timescale 1ns / 1ps
`default_nettype none

module lmsc_thresh (
  input  wire logic [lmsc_pkg::LVL_W-1:0] min_lvl,
  input  wire logic [lmsc_pkg::LVL_W-1:0] max_lvl,
  output logic      [lmsc_pkg::LVL_W-1:0] light_lvl,
  output logic      [lmsc_pkg::LVL_W-1:0] dark_lvl
);
  import lmsc_pkg::*;

  logic [LVL_W-1:0]    lo;
  logic [LVL_W-1:0]    hi;
  logic [LVL_W-1:0]    delta;
  logic [SCALED_W-1:0] scaled;
  logic [QUART_W-1:0]  quart;
  logic [PROD_W-1:0]   prod;
  logic [LVL_W-1:0]    quot;
  logic [SCALED_W-1:0] rem;

  // Order the pair so that the difference is never negative.
  always_comb begin
    if (max_lvl < min_lvl) begin
      lo = max_lvl;
      hi = min_lvl;
    end else begin
      lo = min_lvl;
      hi = max_lvl;
    end
  end

  // 7*delta/20 is taken as (7*delta >> 2) / 5, the last step by reciprocal multiply.
  assign delta  = hi - lo;
  assign scaled = SCALED_W'({delta, 3'b000}) - SCALED_W'(delta);
  assign quart  = scaled[SCALED_W-1:2];
  assign prod   = PROD_W'(quart) * PROD_W'(DIV5_MUL);
  assign quot   = LVL_W'(prod[PROD_W-1:DIV5_SHIFT]);
  assign rem    = scaled - SCALED_W'(SCALED_W'(quot) * SCALED_W'(20));

  // The upper threshold rounds the subtracted part up, which truncates the whole.
  assign dark_lvl  = lo + quot;
  assign light_lvl = hi - quot - LVL_W'(rem != '0);

endmodule

`default_nettype wire

// File: hw/rtl/lmsc_in_stage.sv
// Input register that holds one command transaction ahead of the core.
`timescale 1ns / 1ps
`default_nettype none

module lmsc_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire lmsc_pkg::item_t  in_item,
  output logic                  in_ready,
  input  wire logic             take,
  output lmsc_pkg::stage_t      stage
);
  import lmsc_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The register takes a new transaction when empty or when the core drains it.
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/lmsc_core.sv
// Controller state, command decode and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lmsc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lmsc_pkg::stage_t stage,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lmsc_pkg::res_t        res
);
  import lmsc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP = 2'd0,
    MODE_CAL  = 2'd1,
    MODE_SEEK = 2'd2
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_LIGHT = 2'd0,
    PH_DARK  = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  mode_t              mode_r, mode_nxt;
  phase_t             phase_r, phase_nxt;
  logic [LVL_W-1:0]   min_r, min_nxt;
  logic [LVL_W-1:0]   max_r, max_nxt;
  logic [LVL_W-1:0]   light_r, light_nxt;
  logic [LVL_W-1:0]   dark_r, dark_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               out_valid_r;
  res_t               res_r, res_nxt;

  logic [LVL_W-1:0]   smp;
  logic [LVL_W-1:0]   cal_min;
  logic [LVL_W-1:0]   cal_max;
  logic [LVL_W-1:0]   cal_light;
  logic [LVL_W-1:0]   cal_dark;
  act_t               act;
  logic [SPEED_W-1:0] mspd;
  logic               stat;

  // A transaction moves on when the result register is free or being emptied.
  assign take = stage.valid && (!out_valid_r || out_ready);

  // Calibration widens the seen range with the sample and thresholds follow.
  assign smp     = LVL_W'(stage.item.light_sample);
  assign cal_min = (smp < min_r) ? smp : min_r;
  assign cal_max = (smp > max_r) ? smp : max_r;

  lmsc_thresh u_thresh (
    .min_lvl   (cal_min),
    .max_lvl   (cal_max),
    .light_lvl (cal_light),
    .dark_lvl  (cal_dark)
  );

  // Command decode and the next state.
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    light_nxt = light_r;
    dark_nxt  = dark_r;
    speed_nxt = speed_r;
    act       = ACT_NONE;
    mspd      = '0;
    stat      = 1'b0;
    unique case (stage.item.command)
      CMD_TICK: begin
        unique case (mode_r)
          MODE_CAL: begin
            min_nxt   = cal_min;
            max_nxt   = cal_max;
            light_nxt = cal_light;
            dark_nxt  = cal_dark;
          end
          MODE_SEEK: begin
            unique case (phase_r)
              PH_LIGHT: begin
                if (smp > light_r) begin
                  phase_nxt = PH_DARK;
                end
                act  = ACT_FWD;
                mspd = speed_r;
              end
              PH_DARK: begin
                if (smp < dark_r) begin
                  phase_nxt = PH_DONE;
                end
                act  = ACT_FWD;
                mspd = speed_r;
              end
              default: begin
                mode_nxt = MODE_STOP;
                act      = ACT_BRAKE;
              end
            endcase
          end
          default: begin
            act = ACT_BRAKE;
          end
        endcase
      end
      CMD_STOP: begin
        mode_nxt = MODE_STOP;
        act      = ACT_BRAKE;
      end
      CMD_SEEK: begin
        speed_nxt = stage.item.seek_speed;
        phase_nxt = PH_LIGHT;
        mode_nxt  = MODE_SEEK;
      end
      CMD_INIT: begin
        mode_nxt = MODE_CAL;
        max_nxt  = '0;
        min_nxt  = MIN_INIT;
      end
      CMD_STATUS: begin
        stat = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result fields report the state after the command.
  always_comb begin
    res_nxt.motor_action = act;
    res_nxt.motor_speed  = mspd;
    res_nxt.mode_now     = mode_nxt;
    res_nxt.phase_now    = phase_nxt;
    res_nxt.light_level  = light_nxt;
    res_nxt.dark_level   = dark_nxt;
    res_nxt.status_valid = stat;
    res_nxt.sample_echo  = stat ? stage.item.light_sample : '0;
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOP;
      phase_r     <= PH_LIGHT;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
      light_r     <= LIGHT_RST;
      dark_r      <= DARK_RST;
      speed_r     <= SPEED_RST;
      out_valid_r <= 1'b0;
    end else if (take) begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      light_r     <= light_nxt;
      dark_r      <= dark_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // A stop command always leaves the controller stopped.
  a_stop_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    take && (stage.item.command == CMD_STOP) |=> mode_r == MODE_STOP)
    else $error("stop command did not stop the controller");

  // The dark threshold never rises above the light threshold.
  a_thresh_order: assert property (@(posedge clk) disable iff (!rst_n)
    dark_r <= light_r)
    else $error("dark threshold above light threshold");

  // A nonzero drive speed only goes out with a forward action.
  a_speed_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.motor_speed != '0) |-> res_r.motor_action == ACT_FWD)
    else $error("motor speed reported without forward drive");

  // A status answer never moves the motor.
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status_valid |-> res_r.motor_action == ACT_NONE)
    else $error("status answer carries a motor action");

  // A seek command stores its speed and restarts the search for light.
  a_seek_start: assert property (@(posedge clk) disable iff (!rst_n)
    take && (stage.item.command == CMD_SEEK)
      |=> (speed_r == $past(stage.item.seek_speed)) && (phase_r == PH_LIGHT))
    else $error("seek command did not restart the search");

endmodule

`default_nettype wire

// File: hw/rtl/light_mark_seek_controller.sv
// Top level of the light-mark seek controller.
// Every command transaction yields exactly one result transaction, in order. A command
// passes an input register and then the result register, which offers its result. One
// command is taken every cycle as long as results are drained, and while a result waits
// one more command can still enter the input register. The rate is set by the state
// update, whose longest path is the calibration tick: a min/max compare, a subtract and
// the constant multiplies that form both thresholds. There is no clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module light_mark_seek_controller (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lmsc_cmd_if.sink    in_ch,
  lmsc_res_if.source  out_ch
);
  import lmsc_pkg::*;

  item_t  in_item;
  stage_t stage;
  logic   take;
  logic   out_valid;
  res_t   res;

  // Gather the command fields into one transaction.
  assign in_item.command      = in_ch.command;
  assign in_item.light_sample = in_ch.light_sample;
  assign in_item.seek_speed   = in_ch.seek_speed;

  lmsc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (take),
    .stage    (stage)
  );

  lmsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  // Spread the result transaction onto the channel.
  assign out_ch.valid        = out_valid;
  assign out_ch.motor_action = res.motor_action;
  assign out_ch.motor_speed  = res.motor_speed;
  assign out_ch.mode_now     = res.mode_now;
  assign out_ch.phase_now    = res.phase_now;
  assign out_ch.light_level  = res.light_level;
  assign out_ch.dark_level   = res.dark_level;
  assign out_ch.status_valid = res.status_valid;
  assign out_ch.sample_echo  = res.sample_echo;

endmodule

`default_nettype wire

// File: verif/lmsc_tb_pkg.sv
// Mode and phase codes plus the result scoreboard used by the seek controller testbench.
`timescale 1ns / 1ps

package lmsc_tb_pkg;
  import lmsc_pkg::*;

  // Mode codes as they appear in mode_now.
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEEK = 2'd2;

  // Seek phase codes as they appear in phase_now.
  localparam logic [PHASE_W-1:0] PH_LIGHT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DARK  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE  = 2'd2;

  // Command codes that the block must treat as no change.
  localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

  class lmsc_scoreboard;
    // Shadow copy of the controller state.
    logic [MODE_W-1:0]  ctl_mode;
    logic [PHASE_W-1:0] ctl_phase;
    logic [LVL_W-1:0]   min_seen;
    logic [LVL_W-1:0]   max_seen;
    logic [LVL_W-1:0]   light_level;
    logic [LVL_W-1:0]   dark_level;
    logic [SPEED_W-1:0] drive_speed;

    res_t expected_results[$];
    int   mismatches;
    int   results_checked;
    int   marks_found;

    function new();
      mismatches      = 0;
      results_checked = 0;
      marks_found     = 0;
      ctl_mode        = MODE_STOP;
      ctl_phase       = PH_LIGHT;
      min_seen        = LVL_W'(250);
      max_seen        = LVL_W'(500);
      drive_speed     = SPEED_W'(5);
      refresh_levels();
    endfunction

    // Both thresholds sit 35 percent of the span inside the min/max window.
    function void refresh_levels();
      int lo, hi, span, swap;
      lo = min_seen;
      hi = max_seen;
      if (hi < lo) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      span = hi - lo;
      dark_level  = LVL_W'(lo + (7 * span) / 20);
      light_level = LVL_W'((20 * hi - 7 * span) / 20);
    endfunction

    // Advances the shadow state by one command and returns the result it produces.
    function res_t step_controller(item_t it);
      res_t r;
      r = '0;
      r.motor_action = ACT_NONE;
      case (it.command)
        CMD_TICK: begin
          if (ctl_mode == MODE_CAL) begin
            if (LVL_W'(it.light_sample) < min_seen) min_seen = LVL_W'(it.light_sample);
            if (LVL_W'(it.light_sample) > max_seen) max_seen = LVL_W'(it.light_sample);
            refresh_levels();
          end else if (ctl_mode == MODE_SEEK) begin
            if (ctl_phase == PH_LIGHT) begin
              if (LVL_W'(it.light_sample) > light_level) ctl_phase = PH_DARK;
            end else if (ctl_phase == PH_DARK) begin
              if (LVL_W'(it.light_sample) < dark_level) begin
                ctl_phase = PH_DONE;
                marks_found++;
              end
            end else begin
              ctl_mode = MODE_STOP;
              r.motor_action = ACT_BRAKE;
            end
            if (ctl_mode == MODE_SEEK) begin
              r.motor_action = ACT_FWD;
              r.motor_speed  = drive_speed;
            end
          end else begin
            r.motor_action = ACT_BRAKE;
          end
        end
        CMD_STOP: begin
          ctl_mode = MODE_STOP;
          r.motor_action = ACT_BRAKE;
        end
        CMD_SEEK: begin
          drive_speed = it.seek_speed;
          ctl_phase   = PH_LIGHT;
          ctl_mode    = MODE_SEEK;
        end
        CMD_INIT: begin
          ctl_mode = MODE_CAL;
          max_seen = '0;
          min_seen = LVL_W'(1) << SAMPLE_BITS;
        end
        CMD_STATUS: begin
          r.status_valid = 1'b1;
          r.sample_echo  = it.light_sample;
        end
        default: begin
        end
      endcase
      r.mode_now    = ctl_mode;
      r.phase_now   = ctl_phase;
      r.light_level = light_level;
      r.dark_level  = dark_level;
      return r;
    endfunction

    function void note_input(item_t it);
      expected_results.push_back(step_controller(it));
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("MISMATCH result %0d: %s got %0d expected %0d", results_checked, what, got,
               want);
    endtask

    // Compares one result transaction against the oldest expectation.
    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.motor_action !== want.motor_action)
          report_mismatch("motor_action", got.motor_action, want.motor_action);
        if (got.motor_speed !== want.motor_speed)
          report_mismatch("motor_speed", got.motor_speed, want.motor_speed);
        if (got.mode_now !== want.mode_now)
          report_mismatch("mode_now", got.mode_now, want.mode_now);
        if (got.phase_now !== want.phase_now)
          report_mismatch("phase_now", got.phase_now, want.phase_now);
        if (got.light_level !== want.light_level)
          report_mismatch("light_level", got.light_level, want.light_level);
        if (got.dark_level !== want.dark_level)
          report_mismatch("dark_level", got.dark_level, want.dark_level);
        if (got.status_valid !== want.status_valid)
          report_mismatch("status_valid", got.status_valid, want.status_valid);
        if (got.sample_echo !== want.sample_echo)
          report_mismatch("sample_echo", got.sample_echo, want.sample_echo);
      end
      results_checked++;
    endtask
  endclass

endpackage

// File: verif/light_mark_seek_controller_tb.sv
// Self-checking testbench of the light-mark seek controller with random stalls on both sides.
`timescale 1ns / 1ps

module light_mark_seek_controller_tb;
  import lmsc_pkg::*;
  import lmsc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int ITEM_TARGET = 700;
  localparam int QUIET_AFTER = 620;

  logic clk;
  logic rst_n;

  lmsc_cmd_if in_ch();
  lmsc_res_if out_ch();

  light_mark_seek_controller u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lmsc_scoreboard sb;

  int  cycle_count;
  int  items_sent;
  int  cmd_seen [8];
  bit  quiet;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  start_long_hold;
  int  long_hold_left;
  int  rx_gap;
  int  long_holds;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("light_mark_seek_controller test failed");
      $finish;
    end
  end

  // Transaction monitor: note accepted commands and check accepted results.
  always @(posedge clk) begin
    item_t it;
    res_t  got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.command      = in_ch.command;
        it.light_sample = in_ch.light_sample;
        it.seek_speed   = in_ch.seek_speed;
        cmd_seen[in_ch.command]++;
        sb.note_input(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.motor_action = out_ch.motor_action;
        got.motor_speed  = out_ch.motor_speed;
        got.mode_now     = out_ch.mode_now;
        got.phase_now    = out_ch.phase_now;
        got.light_level  = out_ch.light_level;
        got.dark_level   = out_ch.dark_level;
        got.status_valid = out_ch.status_valid;
        got.sample_echo  = out_ch.sample_echo;
        sb.check_result(got);
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      out_ch.ready = 1'b0;
      long_hold_left--;
    end else if (start_long_hold) begin
      start_long_hold = 1'b0;
      long_hold_left  = LONG_HOLD - 1;
      long_holds++;
      out_ch.ready = 1'b0;
    end else if (rx_gap > 0) begin
      out_ch.ready = 1'b0;
      rx_gap--;
    end else if (!quiet && rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 14) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Offers one command and returns at the falling edge after it was taken.
  task send_cmd(logic [CMD_W-1:0] c, logic [SAMPLE_BITS-1:0] s, logic [SPEED_W-1:0] v);
    if (!quiet && tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.command      = c;
    in_ch.light_sample = s;
    in_ch.seek_speed   = v;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    quiet = (items_sent >= QUIET_AFTER);
  endtask

  // Picks a sample that tends to move the seek phase forward.
  function automatic logic [SAMPLE_BITS-1:0] steer_sample();
    int lt, dt;
    lt = sb.light_level;
    dt = sb.dark_level;
    if (sb.ctl_phase == PH_LIGHT && lt < 1023 && $urandom_range(0, 9) < 6)
      return SAMPLE_BITS'($urandom_range(lt + 1, 1023));
    if (sb.ctl_phase == PH_DARK && dt > 0 && $urandom_range(0, 9) < 6)
      return SAMPLE_BITS'($urandom_range(0, (dt > 1024) ? 1023 : dt - 1));
    return SAMPLE_BITS'($urandom_range(0, 1023));
  endfunction

  // Calibration samples, with the range extremes mixed in.
  function automatic logic [SAMPLE_BITS-1:0] cal_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 1023));
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int n, k;
    bit held, drained;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.light_sample = '0;
    in_ch.seek_speed = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    start_long_hold = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: every command, unused codes, field extremes and a full seek.
    send_cmd(CMD_TICK, 10'd0, 8'd0);
    send_cmd(CMD_STATUS, 10'd1023, 8'd255);
    send_cmd(CMD_STATUS, 10'd0, 8'd0);
    send_cmd(CMD_RSV5, 10'd1023, 8'd255);
    send_cmd(CMD_RSV6, 10'd0, 8'd0);
    send_cmd(CMD_RSV7, 10'd1023, 8'd255);
    send_cmd(CMD_SEEK, 10'd0, 8'd255);
    send_cmd(CMD_TICK, 10'd0, 8'd0);
    send_cmd(CMD_TICK, 10'd1023, 8'd0);
    send_cmd(CMD_TICK, 10'd1023, 8'd0);
    send_cmd(CMD_TICK, 10'd0, 8'd0);
    send_cmd(CMD_TICK, 10'd512, 8'd0);
    send_cmd(CMD_TICK, 10'd512, 8'd0);
    send_cmd(CMD_SEEK, 10'd413, 8'd0);
    send_cmd(CMD_TICK, 10'd413, 8'd0);
    send_cmd(CMD_STOP, 10'd0, 8'd0);
    // Thresholds stay put after initialize until the first calibration tick.
    send_cmd(CMD_INIT, 10'd0, 8'd0);
    send_cmd(CMD_STATUS, 10'd700, 8'd0);
    send_cmd(CMD_TICK, 10'd600, 8'd0);
    send_cmd(CMD_TICK, 10'd0, 8'd0);
    send_cmd(CMD_TICK, 10'd1023, 8'd0);
    send_cmd(CMD_SEEK, 10'd0, 8'd128);
    // A single-sample calibration gives a zero span.
    send_cmd(CMD_INIT, 10'd0, 8'd0);
    send_cmd(CMD_TICK, 10'd1023, 8'd0);
    send_cmd(CMD_SEEK, 10'd1023, 8'd1);

    // Random part, mostly well-formed calibrate-then-seek runs.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (!held && items_sent >= 250) begin
        held = 1'b1;
        start_long_hold = 1'b1;
      end
      if (!drained && items_sent >= 450) begin
        drained = 1'b1;
        in_ch.valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_cmd(CMD_INIT, 10'($urandom), 8'($urandom));
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) send_cmd(CMD_TICK, cal_sample(), 8'($urandom));
          if ($urandom_range(0, 3) == 0) send_cmd(CMD_STATUS, 10'($urandom), 8'($urandom));
          send_cmd(CMD_SEEK, 10'($urandom), 8'($urandom));
          n = $urandom_range(3, 15);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
              send_cmd(CMD_STATUS, 10'($urandom), 8'($urandom));
            else
              send_cmd(CMD_TICK, steer_sample(), 8'($urandom));
          end
        end
        5, 6: begin
          send_cmd(CMD_SEEK, 10'($urandom), 8'($urandom));
          n = $urandom_range(2, 12);
          for (k = 0; k < n; k++) send_cmd(CMD_TICK, steer_sample(), 8'($urandom));
        end
        7: begin
          // Broken runs: seek cut short by stop or a fresh calibration.
          send_cmd(CMD_SEEK, 10'($urandom), 8'($urandom));
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) send_cmd(CMD_TICK, steer_sample(), 8'($urandom));
          if ($urandom_range(0, 1) == 0)
            send_cmd(CMD_STOP, 10'($urandom), 8'($urandom));
          else
            send_cmd(CMD_INIT, 10'($urandom), 8'($urandom));
        end
        default: begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++)
            send_cmd(3'($urandom_range(0, 7)), 10'($urandom), 8'($urandom));
        end
      endcase
    end
    in_ch.valid = 1'b0;

    // Drain, then watch for stray results before the final check.
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch("results never delivered", 0, sb.expected_results.size());

    $display("Covered %0d commands: %0d ticks, %0d stops, %0d seeks, %0d inits, %0d status, %0d other.",
             items_sent, cmd_seen[CMD_TICK], cmd_seen[CMD_STOP], cmd_seen[CMD_SEEK],
             cmd_seen[CMD_INIT], cmd_seen[CMD_STATUS],
             cmd_seen[CMD_RSV5] + cmd_seen[CMD_RSV6] + cmd_seen[CMD_RSV7]);
    $display("Checked %0d results, %0d marks found, %0d long output hold-offs, %0d mismatches.",
             sb.results_checked, sb.marks_found, long_holds, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("light_mark_seek_controller test passed");
    end else begin
      $display("light_mark_seek_controller test failed");
    end
    $finish;
  end

endmodule
